FILE: hdl/ordered_list_store_core_assert.svh
// ----------------------------------------------------------------------------
// ordered_list_store_core_assert.svh
// Assertion macros used by the ordered list store RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define ORDERED_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define OLST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define OLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// Types, constants and ring helpers for the ordered list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olst_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KEY_W-1:0]   key_t;

  localparam count_t CAP_COUNT = count_t'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  // Ring position base + off, with off below CAPACITY
  function automatic ptr_t ring_add(ptr_t base, count_t off);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W+1)'(base) + (COUNT_W+1)'(off);
    if (sum >= (COUNT_W+1)'(CAPACITY)) begin
      sum = sum - (COUNT_W+1)'(CAPACITY);
    end
    return ptr_t'(sum);
  endfunction

  function automatic ptr_t ring_dec(ptr_t p);
    return (p == '0) ? ptr_t'(CAPACITY - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic ptr_t ring_inc(ptr_t p);
    return (p == ptr_t'(CAPACITY - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // Ring slot of logical position i (0 is the logical front)
  function automatic ptr_t slot_of(ptr_t front, count_t cnt, logic rev, count_t i);
    count_t off;
    off = rev ? count_t'(cnt - 1'b1 - i) : i;
    return ring_add(front, off);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/olst_if.sv
// ----------------------------------------------------------------------------
// olst_if
// Command and response channels of the ordered list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface olst_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [olst_pkg::CMD_W-1:0]        cmd;
  logic signed [olst_pkg::KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface olst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olst_pkg::STATUS_W-1:0] status;
  logic [olst_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

FILE: hdl/olst_ram.sv
// ----------------------------------------------------------------------------
// olst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/ordered_list_store_core.sv
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Ordered list of signed 32-bit values kept in a ring buffer in RAM.
// ----------------------------------------------------------------------------
// Push front/back, pop front/back and reverse finish in the cycle of their
// transfer; the response is registered and shows the next cycle. Reverse only
// flips which ring end is the logical front. Remove-key scans the list from the
// logical front at one entry per cycle, then closes the gap one entry per cycle
// through the single RAM read and write port. One command is in work at a time;
// a new command is taken in the idle state once the response register is free
// or being drained. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_store_core_assert.svh"

module ordered_list_store_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olst_cmd_if.sink  cmd_i,
  olst_rsp_if.source rsp_o
);

  import olst_pkg::*;

  state_e  state_q, state_d;
  ptr_t    front_q, front_d;
  count_t  count_q, count_d;
  logic    rev_q, rev_d;
  count_t  idx_q, idx_d;
  logic    pend_vld_q, pend_vld_d;
  count_t  pend_idx_q, pend_idx_d;
  key_t    key_q, key_d;
  status_e status_q, status_d;
  logic    rsp_vld_q, rsp_vld_d;
  status_e rsp_status_q, rsp_status_d;
  count_t  rsp_count_q, rsp_count_d;

  logic    mem_we;
  ptr_t    mem_waddr;
  key_t    mem_wdata;
  ptr_t    mem_raddr;
  key_t    mem_rdata;

  logic    cmd_fire;
  cmd_e    cmd_in;
  logic    is_empty;
  logic    is_full;
  logic    rsp_free;
  logic    hit;
  logic    last;
  logic    idx_live;
  status_e imm_status;

  olst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Handshake and shared conditions
  assign rsp_free    = !rsp_vld_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && rsp_free;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign cmd_in      = cmd_e'(cmd_i.cmd);
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q >= CAP_COUNT);
  assign hit         = pend_vld_q && (mem_rdata == key_q);
  assign last        = pend_vld_q && (pend_idx_q == count_t'(count_q - 1'b1));
  assign idx_live    = (idx_q < count_q);

  assign rsp_o.valid  = rsp_vld_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.count  = rsp_count_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire && (cmd_in == CMD_REMOVE) && !is_empty) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = S_SHIFT;
        end else if (last) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!idx_live && !pend_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // Datapath, RAM control and response
  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    rev_d        = rev_q;
    idx_d        = idx_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    key_d        = key_q;
    status_d     = status_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    imm_status   = STAT_OK;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = key_q;
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          key_d = cmd_i.key;
          unique case (cmd_in)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (is_full) begin
                imm_status = STAT_FULL;
              end else if ((cmd_in == CMD_PUSH_FRONT) != rev_q) begin
                // add at the low end of the ring
                front_d   = ring_dec(front_q);
                mem_we    = 1'b1;
                mem_waddr = ring_dec(front_q);
                mem_wdata = cmd_i.key;
                count_d   = count_t'(count_q + 1'b1);
              end else begin
                // add at the high end of the ring
                mem_we    = 1'b1;
                mem_waddr = ring_add(front_q, count_q);
                mem_wdata = cmd_i.key;
                count_d   = count_t'(count_q + 1'b1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (is_empty) begin
                imm_status = STAT_EMPTY;
              end else begin
                if ((cmd_in == CMD_POP_FRONT) != rev_q) begin
                  front_d = ring_inc(front_q);
                end
                count_d = count_t'(count_q - 1'b1);
              end
            end
            CMD_REMOVE: begin
              if (is_empty) begin
                imm_status = STAT_EMPTY;
              end else begin
                idx_d      = '0;
                pend_vld_d = 1'b0;
              end
            end
            CMD_REVERSE: begin
              rev_d = !rev_q;
            end
            default: begin
            end
          endcase
          // immediate commands answer at once; a remove answers when done
          if (!((cmd_in == CMD_REMOVE) && !is_empty)) begin
            rsp_vld_d    = 1'b1;
            rsp_status_d = imm_status;
            rsp_count_d  = count_d;
          end
        end
      end
      S_SEARCH: begin
        // issue one read per cycle, compare the data of the previous read
        mem_raddr  = slot_of(front_q, count_q, rev_q, idx_q);
        idx_d      = count_t'(idx_q + 1'b1);
        pend_vld_d = idx_live;
        pend_idx_d = idx_q;
        if (hit) begin
          idx_d      = count_t'(pend_idx_q + 1'b1);
          pend_vld_d = 1'b0;
        end else if (last) begin
          status_d = STAT_NOTFOUND;
        end
      end
      S_SHIFT: begin
        // read entry i+1, write it to entry i in the next cycle
        if (idx_live) begin
          mem_raddr  = slot_of(front_q, count_q, rev_q, idx_q);
          pend_vld_d = 1'b1;
          pend_idx_d = count_t'(idx_q - 1'b1);
          idx_d      = count_t'(idx_q + 1'b1);
        end else begin
          pend_vld_d = 1'b0;
        end
        if (pend_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(front_q, count_q, rev_q, pend_idx_q);
          mem_wdata = mem_rdata;
        end
        // gap closed: drop the logical back entry
        if (!idx_live && !pend_vld_q) begin
          if (rev_q) begin
            front_d = ring_inc(front_q);
          end
          count_d  = count_t'(count_q - 1'b1);
          status_d = STAT_OK;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_vld_d    = 1'b1;
          rsp_status_d = status_q;
          rsp_count_d  = count_q;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      front_q    <= '0;
      count_q    <= '0;
      rev_q      <= 1'b0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      rev_q      <= rev_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    key_q        <= key_d;
    status_q     <= status_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  // Checks
  `OLST_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CAP_COUNT, "count above capacity")
  `OLST_ASSERT_NOW(a_ready_idle, clk_i, rst_ni, cmd_i.ready, state_q == S_IDLE, "ready outside idle")
  `OLST_ASSERT_NOW(a_search_no_write, clk_i, rst_ni, state_q == S_SEARCH, !mem_we, "write during search")
  `OLST_ASSERT_NOW(a_full_count, clk_i, rst_ni, rsp_vld_q && (rsp_status_q == STAT_FULL), rsp_count_q == CAP_COUNT, "full status with room left")
  `OLST_ASSERT_NEXT(a_remove_search, clk_i, rst_ni, cmd_fire && (cmd_in == CMD_REMOVE) && !is_empty, state_q == S_SEARCH, "remove did not start a search")

endmodule

`default_nettype wire
